### rtl/core/sti_pkg.sv
// Shared types and codes for the sorted table block.
package sti_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 4;
  localparam int CNT_W     = 5;
  localparam int MAX_RES   = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_DUMP   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] entry_value;
    logic [POS_W-1:0]        entry_position;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cell_ctl_t;

endpackage

### rtl/core/sti_cell.sv
// One storage cell of the sorted table chain.
module sti_cell
  import sti_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                            clk,
  input  cell_ctl_t                       ctl,
  input  logic [$clog2(DEPTH+1)-1:0]      count,
  input  logic signed [VAL_W-1:0]         head_val,
  input  logic                            left_ge,
  input  logic signed [VAL_W-1:0]         left_val,
  input  logic signed [VAL_W-1:0]         right_val,
  output logic                            ge,
  output logic signed [VAL_W-1:0]         val
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (IW > POS_W) ? IW : POS_W;
  localparam logic [CW-1:0]   IDX_C = CW'(IDX);
  localparam logic [CMPW-1:0] IDX_P = CMPW'(IDX);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Cells at or past the count, or holding a larger value, move up on insert.
  assign ge  = (IDX_C >= count) || (val_r > ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (ge) begin
          val_nxt = left_ge ? left_val : ctl.value;
        end
      end
      CELL_REMOVE: begin
        if (CMPW'(ctl.position) <= IDX_P) begin
          val_nxt = right_val;
        end
      end
      CELL_ROTATE: begin
        val_nxt = (IDX_C == count - CW'(1)) ? head_val : right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/core/sorted_table_insert_remove.sv
// Top level of the sorted table: cell chain, control sequencer and result register.
//
// This block keeps up to DEPTH signed 32-bit values in ascending order in a row
// of cells, one value per cell. In an insert or a remove, every cell compares
// its value with the new one, or its index with the requested position, and
// takes its own, its left or its right neighbor's value at the same clock
// edge, so the table is updated and the single result is registered at that
// edge. Equal values keep arrival order, since a new value goes after every
// entry equal to it. A dump rotates the chain toward cell 0 once per cycle
// while the result side keeps up and emits the value leaving cell 0 (at most
// 16 entries are reported, the rotation still runs count steps so the table
// ends in its original order), and no new input is taken until it ends.
// Between operations, the input side takes a new transfer in any cycle in
// which the result register is empty or being drained. Rejected operations
// (insert into a full table, remove at a position not below the count) and a
// dump of an empty table give one result with a status code and leave the
// table unchanged. Kind 3 is accepted and dropped without a result. The cells
// need no reset: only cells below the count are ever reported.
module sorted_table_insert_remove
  import sti_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCMP = (CW > POS_W) ? CW : POS_W;

  fsm_t            state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  cell_ctl_t               ctl;
  logic                    ge_w  [DEPTH];
  logic signed [VAL_W-1:0] val_w [DEPTH];
  logic [IW-1:0]           at_idx;

  logic out_free;
  logic in_fire;
  logic table_full;
  logic pos_bad;
  logic dump_emit;
  logic dump_adv;
  logic dump_end;

  // The result register can take a new item when empty or when its item leaves.
  assign out_free   = !out_valid_r || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign table_full = (count_r == CW'(DEPTH));
  assign pos_bad    = RCMP'(in_data.position) >= RCMP'(count_r);

  // During a dump only the first MAX_RES rotation steps need the result slot.
  assign dump_emit = (int'(step_r) < MAX_RES);
  assign dump_adv  = (state_r == FSM_DUMP) && (!dump_emit || out_free);
  assign dump_end  = (step_r == count_r - CW'(1));

  // The chain: each cell sees its neighbors and the head of the table.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    lge;
    logic signed [VAL_W-1:0] lval;
    logic signed [VAL_W-1:0] rval;
    if (i == 0) begin : g_first
      assign lge  = 1'b0;
      assign lval = '0;
    end else begin : g_mid
      assign lge  = ge_w[i-1];
      assign lval = val_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rval = val_w[i];
    end else begin : g_inner
      assign rval = val_w[i+1];
    end
    sti_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .head_val  (val_w[0]),
      .left_ge   (lge),
      .left_val  (lval),
      .right_val (rval),
      .ge        (ge_w[i]),
      .val       (val_w[i])
    );
  end

  // The insert point is the one cell that moves while its left neighbor stays.
  always_comb begin
    at_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ge_w[i] && ((i == 0) || !ge_w[(i == 0) ? 0 : i - 1])) begin
        at_idx = at_idx | IW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire && (in_data.kind == KIND_DUMP) && (count_r != '0)) begin
          state_nxt = FSM_DUMP;
        end
      end
      FSM_DUMP: begin
        if (dump_adv && dump_end) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs, cell commands and datapath registers.
  always_comb begin
    in_ready      = 1'b0;
    ctl.op        = CELL_HOLD;
    ctl.value     = in_data.value;
    ctl.position  = in_data.position;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      FSM_IDLE: begin
        in_ready = out_free;
        step_nxt = '0;
        if (in_fire) begin
          out_data_nxt.entry_value    = '0;
          out_data_nxt.entry_position = '0;
          out_data_nxt.status         = ST_OK;
          out_data_nxt.entry_count    = CNT_W'(count_r);
          out_data_nxt.last           = 1'b1;
          case (in_data.kind)
            KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ctl.op                      = CELL_INSERT;
                count_nxt                   = count_r + CW'(1);
                out_data_nxt.entry_position = POS_W'(at_idx);
                out_data_nxt.entry_count    = CNT_W'(count_r + CW'(1));
              end
            end
            KIND_REMOVE: begin
              out_valid_nxt = 1'b1;
              if (pos_bad) begin
                out_data_nxt.status = ST_RANGE;
              end else begin
                ctl.op                      = CELL_REMOVE;
                count_nxt                   = count_r - CW'(1);
                out_data_nxt.entry_position = in_data.position;
                out_data_nxt.entry_count    = CNT_W'(count_r - CW'(1));
              end
            end
            KIND_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end
            end
            default: out_valid_nxt = out_valid_r && !out_ready;
          endcase
        end
      end
      FSM_DUMP: begin
        if (dump_adv) begin
          ctl.op   = CELL_ROTATE;
          step_nxt = step_r + CW'(1);
          if (dump_emit) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.entry_value    = val_w[0];
            out_data_nxt.entry_position = POS_W'(step_r);
            out_data_nxt.status         = ST_OK;
            out_data_nxt.entry_count    = CNT_W'(count_r);
            out_data_nxt.last           = dump_end || (int'(step_r) == MAX_RES - 1);
          end
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  // No input transfer while a dump is running.
  a_no_in_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DUMP) |-> !in_ready)
    else $error("input taken during dump");

  // An accepted insert into a table with room adds exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.kind == KIND_INSERT) && !table_full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the table");

  // A dump leaves the entry count unchanged.
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DUMP) |=> $stable(count_r))
    else $error("entry count changed during dump");

endmodule
